// File: hw/rtl/line_sensor_average_threshold_assert.svh
// ----------------------------------------------------------------------------
// Line sensor threshold assertion macros
// Shared concurrent assertion forms for the line sensor checker.
// ----------------------------------------------------------------------------
`ifndef LINE_SENSOR_AVERAGE_THRESHOLD_ASSERT_SVH
`define LINE_SENSOR_AVERAGE_THRESHOLD_ASSERT_SVH

// Property checked on every clock edge outside reset.
`define LSAT_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("line sensor check failed");

// Property checked on every clock edge, reset included.
`define LSAT_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("line sensor check failed");

`endif

// File: hw/rtl/lsat_pkg.sv
// ----------------------------------------------------------------------------
// Line sensor threshold package
// Shared types and fixed constants of the line sensor averaging block.
// ----------------------------------------------------------------------------
`default_nettype none

package lsat_pkg;

   localparam int CHANNELS = 8;
   localparam int SAMPLE_W = 10;
   localparam int QUERY_W  = 3;

   localparam logic [SAMPLE_W-1:0] SAMPLE_MAX   = 10'd1000;
   localparam logic [SAMPLE_W-1:0] MARGIN_RESET = 10'd60;

   typedef enum logic {
      REQ_MEASURE   = 1'b0,
      REQ_CALIBRATE = 1'b1
   } req_kind_type;

   typedef logic [SAMPLE_W-1:0]        sample_type;
   typedef sample_type [CHANNELS-1:0]  sample_vec_type;
   typedef logic [CHANNELS-1:0]        mask_type;
   typedef logic [QUERY_W-1:0]         query_type;

   // Clamp a reading to the sensor full scale.
   function automatic sample_type clip_sample(input sample_type value);
      return (value > SAMPLE_MAX) ? SAMPLE_MAX : value;
   endfunction

endpackage

`default_nettype wire

// File: hw/rtl/lsat_hit_eval.sv
// ----------------------------------------------------------------------------
// Line sensor hit evaluation
// Compares each channel average against its calibrated baseline plus margin.
// ----------------------------------------------------------------------------
`default_nettype none

module lsat_hit_eval #(
   parameter int CAL_COUNT = 64,
   parameter int ACC_W     = 16
) (
   input  lsat_pkg::sample_vec_type                    average,
   input  logic [lsat_pkg::CHANNELS-1:0][ACC_W-1:0]    cal_sum,
   input  lsat_pkg::sample_type                        margin,
   output lsat_pkg::mask_type                          hit
);
   import lsat_pkg::*;

   logic [SAMPLE_W:0]  diff   [CHANNELS];
   logic [ACC_W-1:0]   scaled [CHANNELS];

   // The baseline is the truncated quotient cal_sum / CAL_COUNT, so
   // avg > baseline + margin holds exactly when (avg - margin) is positive
   // and (avg - margin) * CAL_COUNT exceeds cal_sum.
   for (genvar c = 0; c < CHANNELS; c++) begin : g_chan
      assign diff[c]   = {1'b0, average[c]} - {1'b0, margin};
      assign scaled[c] = ACC_W'(diff[c][SAMPLE_W-1:0]) * ACC_W'(CAL_COUNT);
      assign hit[c]    = !diff[c][SAMPLE_W] && (diff[c] != '0) &&
                         (scaled[c] > cal_sum[c]);
   end

endmodule

`default_nettype wire

// File: hw/rtl/line_sensor_average_threshold.sv
// Each accepted request is registered in the input, average and result stages.
// Throughput: one request per cycle while req_stall is low; the bound is the
// per-channel running-sum update, which reads and rewrites the ring row and sum
// in the same cycle. Reset (synchronous, active high) clears rings, sums,
// averages, baselines, calibration state and hit flags and sets the margin to 60.
// ----------------------------------------------------------------------------
// Line sensor moving average threshold detector
// Eight-channel moving average with calibrated baseline and hit flags.
// ----------------------------------------------------------------------------
`default_nettype none

module line_sensor_average_threshold #(
   parameter int MA_DEPTH  = 4,
   parameter int CAL_COUNT = 64
) (
   input  logic                  clock,
   input  logic                  reset,

   input  logic                  csr_write_enable,
   input  lsat_pkg::sample_type  csr_write_data,

   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_type,
   input  lsat_pkg::sample_type  req_sample_0,
   input  lsat_pkg::sample_type  req_sample_1,
   input  lsat_pkg::sample_type  req_sample_2,
   input  lsat_pkg::sample_type  req_sample_3,
   input  lsat_pkg::sample_type  req_sample_4,
   input  lsat_pkg::sample_type  req_sample_5,
   input  lsat_pkg::sample_type  req_sample_6,
   input  lsat_pkg::sample_type  req_sample_7,
   input  lsat_pkg::query_type   req_query_channel,

   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output lsat_pkg::mask_type    rsp_hit_mask,
   output logic                  rsp_any_hit,
   output logic                  rsp_front_hit,
   output logic                  rsp_right_hit,
   output logic                  rsp_back_hit,
   output logic                  rsp_left_hit,
   output lsat_pkg::sample_type  rsp_query_value,
   output logic                  rsp_cal_done
);
   import lsat_pkg::*;

   localparam int PTR_W     = (MA_DEPTH > 1) ? $clog2(MA_DEPTH) : 1;
   localparam int SUM_W     = $clog2(int'(SAMPLE_MAX) * MA_DEPTH + 1);
   localparam int DIV_SHIFT = SUM_W + 4;
   localparam int RECIP     = ((1 << DIV_SHIFT) + MA_DEPTH - 1) / MA_DEPTH;
   localparam int PROD_W    = SUM_W + DIV_SHIFT + 1;
   localparam int ACC_W     = $clog2(int'(SAMPLE_MAX) * CAL_COUNT + 1);
   localparam int CNT_W     = (CAL_COUNT > 1) ? $clog2(CAL_COUNT) : 1;

   typedef logic [CHANNELS-1:0][SUM_W-1:0] sum_vec_type;
   typedef logic [CHANNELS-1:0][ACC_W-1:0] acc_vec_type;

   // pipeline handshake
   logic free_rsp, free_mid, in_adv, mid_adv, req_acc;

   // input stage
   logic           in_valid_ff, in_valid_in;
   req_kind_type   in_kind_ff, in_kind_in;
   sample_vec_type in_sample_ff, in_sample_in;
   query_type      in_query_ff, in_query_in;

   // average stage
   logic           mid_valid_ff, mid_valid_in;
   req_kind_type   mid_kind_ff, mid_kind_in;
   query_type      mid_query_ff, mid_query_in;
   logic           mid_done_ff, mid_done_in;

   // result stage
   logic           rsp_valid_ff, rsp_valid_in;
   mask_type       rsp_mask_ff, rsp_mask_in;
   sample_type     rsp_query_ff, rsp_query_in;
   logic           rsp_done_ff, rsp_done_in;

   // channel state
   sample_vec_type ring_ff [MA_DEPTH];
   sample_vec_type ring_in [MA_DEPTH];
   logic [PTR_W-1:0] ptr_ff, ptr_in;
   sum_vec_type    sum_ff, sum_in, sum_new;
   sample_vec_type avg_ff, avg_in, avg_new;
   acc_vec_type    acc_ff, acc_in, acc_new;
   acc_vec_type    snap_ff, snap_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   mask_type       flags_ff, flags_in;
   sample_type     margin_ff, margin_in;

   sample_vec_type row_old;
   logic [PROD_W-1:0] prod [CHANNELS];
   logic           cal_last;
   mask_type       hit_new, flags_out;

   assign free_rsp  = !rsp_valid_ff || !rsp_stall;
   assign mid_adv   = mid_valid_ff && free_rsp;
   assign free_mid  = !mid_valid_ff || free_rsp;
   assign in_adv    = in_valid_ff && free_mid;
   assign req_stall = in_valid_ff && !free_mid;
   assign req_acc   = req_valid && !req_stall;

   // input capture, samples clamped on the way in
   always_comb begin
      in_valid_in  = req_acc ? 1'b1 : (in_adv ? 1'b0 : in_valid_ff);
      in_kind_in   = in_kind_ff;
      in_sample_in = in_sample_ff;
      in_query_in  = in_query_ff;
      if (req_acc) begin
         in_kind_in      = req_kind_type'(req_type);
         in_sample_in[0] = clip_sample(req_sample_0);
         in_sample_in[1] = clip_sample(req_sample_1);
         in_sample_in[2] = clip_sample(req_sample_2);
         in_sample_in[3] = clip_sample(req_sample_3);
         in_sample_in[4] = clip_sample(req_sample_4);
         in_sample_in[5] = clip_sample(req_sample_5);
         in_sample_in[6] = clip_sample(req_sample_6);
         in_sample_in[7] = clip_sample(req_sample_7);
         in_query_in     = req_query_channel;
      end
   end

   // running sum, average and calibration accumulate
   always_comb begin
      row_old  = ring_ff[ptr_ff];
      cal_last = (cnt_ff == CNT_W'(CAL_COUNT - 1));
      for (int c = 0; c < CHANNELS; c++) begin
         sum_new[c] = sum_ff[c] - SUM_W'(row_old[c]) + SUM_W'(in_sample_ff[c]);
         // divide by the ring depth through an exact reciprocal
         prod[c]    = PROD_W'(sum_new[c]) * PROD_W'(RECIP);
         avg_new[c] = prod[c][DIV_SHIFT +: SAMPLE_W];
         acc_new[c] = acc_ff[c] + ACC_W'(in_sample_ff[c]);
      end

      ring_in      = ring_ff;
      ptr_in       = ptr_ff;
      sum_in       = sum_ff;
      avg_in       = avg_ff;
      acc_in       = acc_ff;
      snap_in      = snap_ff;
      cnt_in       = cnt_ff;
      mid_valid_in = in_adv ? 1'b1 : (mid_adv ? 1'b0 : mid_valid_ff);
      mid_kind_in  = mid_kind_ff;
      mid_query_in = mid_query_ff;
      mid_done_in  = mid_done_ff;

      if (in_adv) begin
         mid_kind_in  = in_kind_ff;
         mid_query_in = in_query_ff;
         mid_done_in  = 1'b0;
         case (in_kind_ff)
            REQ_MEASURE: begin
               ring_in[ptr_ff] = in_sample_ff;
               sum_in          = sum_new;
               avg_in          = avg_new;
               ptr_in          = (ptr_ff == PTR_W'(MA_DEPTH - 1)) ? '0 : ptr_ff + 1'b1;
            end
            REQ_CALIBRATE: begin
               if (cal_last) begin
                  // keep the batch total; the compare works from it directly
                  snap_in     = acc_new;
                  acc_in      = '0;
                  cnt_in      = '0;
                  mid_done_in = 1'b1;
               end else begin
                  acc_in = acc_new;
                  cnt_in = cnt_ff + 1'b1;
               end
            end
            default: begin
               mid_done_in = 1'b0;
            end
         endcase
      end
   end

   lsat_hit_eval #(
      .CAL_COUNT (CAL_COUNT),
      .ACC_W     (ACC_W)
   ) u_hit_eval (
      .average (avg_ff),
      .cal_sum (snap_ff),
      .margin  (margin_ff),
      .hit     (hit_new)
   );

   // flags and result
   always_comb begin
      flags_out    = (mid_kind_ff == REQ_MEASURE) ? hit_new : flags_ff;
      flags_in     = mid_adv ? flags_out : flags_ff;
      rsp_valid_in = mid_adv ? 1'b1 : (free_rsp ? 1'b0 : rsp_valid_ff);
      rsp_mask_in  = rsp_mask_ff;
      rsp_query_in = rsp_query_ff;
      rsp_done_in  = rsp_done_ff;
      if (mid_adv) begin
         rsp_mask_in  = flags_out;
         rsp_query_in = avg_ff[mid_query_ff];
         rsp_done_in  = mid_done_ff;
      end
      margin_in = csr_write_enable ? csr_write_data : margin_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         mid_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         ring_ff      <= '{default: '0};
         ptr_ff       <= '0;
         sum_ff       <= '0;
         avg_ff       <= '0;
         acc_ff       <= '0;
         snap_ff      <= '0;
         cnt_ff       <= '0;
         flags_ff     <= '0;
         margin_ff    <= MARGIN_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         mid_valid_ff <= mid_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         ring_ff      <= ring_in;
         ptr_ff       <= ptr_in;
         sum_ff       <= sum_in;
         avg_ff       <= avg_in;
         acc_ff       <= acc_in;
         snap_ff      <= snap_in;
         cnt_ff       <= cnt_in;
         flags_ff     <= flags_in;
         margin_ff    <= margin_in;
      end
   end

   // payload registers, hold while stalled
   always_ff @(posedge clock) begin
      in_kind_ff   <= in_kind_in;
      in_sample_ff <= in_sample_in;
      in_query_ff  <= in_query_in;
      mid_kind_ff  <= mid_kind_in;
      mid_query_ff <= mid_query_in;
      mid_done_ff  <= mid_done_in;
      rsp_mask_ff  <= rsp_mask_in;
      rsp_query_ff <= rsp_query_in;
      rsp_done_ff  <= rsp_done_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_hit_mask    = rsp_mask_ff;
   assign rsp_any_hit     = |rsp_mask_ff;
   assign rsp_front_hit   = |rsp_mask_ff[1:0];
   assign rsp_right_hit   = |rsp_mask_ff[3:2];
   assign rsp_back_hit    = |rsp_mask_ff[5:4];
   assign rsp_left_hit    = |rsp_mask_ff[7:6];
   assign rsp_query_value = rsp_query_ff;
   assign rsp_cal_done    = rsp_done_ff;

endmodule

`default_nettype wire

// File: hw/rtl/lsat_checker.sv
// ----------------------------------------------------------------------------
// Line sensor threshold checker
// Port-level assertions on the line sensor block, attached by bind.
// ----------------------------------------------------------------------------
`default_nettype none

`include "line_sensor_average_threshold_assert.svh"

module lsat_checker (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_stall,
   input logic                  rsp_valid,
   input logic                  rsp_stall,
   input lsat_pkg::mask_type    rsp_hit_mask,
   input logic                  rsp_any_hit,
   input logic                  rsp_front_hit,
   input logic                  rsp_right_hit,
   input logic                  rsp_back_hit,
   input logic                  rsp_left_hit,
   input lsat_pkg::sample_type  rsp_query_value,
   input logic                  rsp_cal_done
);

   logic        groups_match;
   logic [18:0] rsp_payload;

   assign groups_match = (rsp_any_hit == (|rsp_hit_mask)) &&
                         (rsp_front_hit == (|rsp_hit_mask[1:0])) &&
                         (rsp_right_hit == (|rsp_hit_mask[3:2])) &&
                         (rsp_back_hit == (|rsp_hit_mask[5:4])) &&
                         (rsp_left_hit == (|rsp_hit_mask[7:6]));
   assign rsp_payload  = {rsp_hit_mask, rsp_query_value, rsp_cal_done};

   // no result may be pending right after reset
   `LSAT_ASSERT_ALWAYS(a_reset_empties, clock, reset |=> !rsp_valid)

   // the input side only backs up when the result side is full and stalled
   `LSAT_ASSERT(a_stall_from_output, clock, reset, req_stall |-> rsp_valid && rsp_stall)

   // group flags follow the hit mask
   `LSAT_ASSERT(a_group_flags, clock, reset, rsp_valid |-> groups_match)

   // a stalled result holds
   `LSAT_ASSERT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))

endmodule

bind line_sensor_average_threshold lsat_checker u_lsat_checker (.*);

`default_nettype wire
